[design/tss_pkg.sv]
package tss_pkg;

  localparam int DATA_W    = 32;
  localparam int WT_W      = 31;
  localparam int IDX_W     = 10;
  localparam int LEN_W     = 11;
  localparam int IT_W      = 7;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ITERS  = 2'd2;

  localparam logic [WT_W-1:0]  STEP_RST = 31'd65536;
  localparam logic [LEN_W-1:0] LEN_RST  = 11'd1024;
  localparam logic [IT_W-1:0]  ITER_RST = 7'd10;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SHRINK = 1'b1;

  localparam logic [1:0] RG_QUAD  = 2'd0;
  localparam logic [1:0] RG_TAIL  = 2'd1;
  localparam logic [1:0] RG_ITER  = 2'd2;
  localparam logic [1:0] RG_RANGE = 2'd3;

  // Shared multiply/divide unit word width and multiplier length.
  localparam int UW        = 72;
  localparam int MUL_STEPS = 31;

  typedef logic [UW-1:0] uword_t;
  typedef logic signed [DATA_W-1:0] data_t;

endpackage

[design/tabulated_shrinkage_solver.sv]
// Tabulated proximal shrinkage solver.
// Input channel (in_valid/in_ready): a beat with in_command = load writes one
// derivative table entry, if its index is below TABLE_DEPTH, and gives no
// result. A beat with in_command = shrink takes in_sample and in_weight and
// gives one result beat (out_shrunk, out_regime) on the output channel.
// Configuration (cfg_we/cfg_index/cfg_data) sets the spacing, table length and
// iteration count; write it only while no shrink is in flight.
// Most multiplies and all divides run on one shared shift-add multiplier /
// restoring divider that handles one bit per cycle, under a small sequencer;
// the table has one write port and one registered read port.
// The block takes one item at a time; in_ready is high only
// while the sequencer is idle.
// The result sits in an output register; if the receiver stalls, the block
// finishes the next shrink and then waits until the register frees up. Load
// beats are taken while a result waits, but not while a finished shrink waits.
// Reset (rst_n low at a clock edge) clears the sequencer and the output valid
// and restores the register defaults; the table is not cleared.
module tabulated_shrinkage_solver #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [tss_pkg::IDX_W-1:0]           in_table_index,
  input  logic signed [tss_pkg::DATA_W-1:0]   in_table_word,
  input  logic signed [tss_pkg::DATA_W-1:0]   in_sample,
  input  logic [tss_pkg::WT_W-1:0]            in_weight,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tss_pkg::DATA_W-1:0]   out_shrunk,
  output logic [1:0]                          out_regime,
  input  logic                                cfg_we,
  input  logic [tss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tss_pkg::WT_W-1:0]            cfg_data
);
  import tss_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int KW = $clog2(TABLE_DEPTH + 1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_PRE  = 5'd1;
  localparam logic [4:0] S_M1   = 5'd2;
  localparam logic [4:0] S_P1   = 5'd3;
  localparam logic [4:0] S_M2   = 5'd4;
  localparam logic [4:0] S_PK   = 5'd5;
  localparam logic [4:0] S_DEC  = 5'd6;
  localparam logic [4:0] S_Q0M  = 5'd7;
  localparam logic [4:0] S_Q0D  = 5'd8;
  localparam logic [4:0] S_Q0R  = 5'd9;
  localparam logic [4:0] S_CHK  = 5'd10;
  localparam logic [4:0] S_KQ   = 5'd11;
  localparam logic [4:0] S_T0   = 5'd12;
  localparam logic [4:0] S_T1   = 5'd13;
  localparam logic [4:0] S_IM   = 5'd14;
  localparam logic [4:0] S_ID   = 5'd15;
  localparam logic [4:0] S_DD   = 5'd16;
  localparam logic [4:0] S_WM   = 5'd17;
  localparam logic [4:0] S_QR   = 5'd18;
  localparam logic [4:0] S_RD   = 5'd19;
  localparam logic [4:0] S_DEN  = 5'd20;
  localparam logic [4:0] S_XN   = 5'd21;
  localparam logic [4:0] S_WAIT = 5'd22;
  localparam logic [4:0] S_DONE = 5'd23;

  localparam logic signed [UW-1:0] SAT_MAX = 72'sd2147483647;
  localparam logic signed [UW-1:0] SAT_MIN = -72'sd2147483648;

  function automatic data_t sat32(input logic signed [UW-1:0] v);
    logic signed [UW-1:0] c;
    c = v;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end
    return $signed(c[DATA_W-1:0]);
  endfunction

  function automatic uword_t abs72(input logic signed [UW-1:0] v);
    return v[UW-1] ? uword_t'(-v) : uword_t'(v);
  endfunction

  // Q16.16 product rounded toward minus infinity, from magnitude and sign.
  function automatic logic signed [UW-1:0] fl16(input logic [UW:0] pm, input logic neg);
    logic [UW:0] up;
    up = neg ? ((pm + 73'd65535) >> 16) : (pm >> 16);
    return neg ? -$signed(up[UW-1:0]) : $signed(up[UW-1:0]);
  endfunction

  // Configuration registers.
  logic [WT_W-1:0]  cfg_step_r;
  logic [LEN_W-1:0] cfg_len_r;
  logic [IT_W-1:0]  cfg_iter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_step_r <= STEP_RST;
      cfg_len_r  <= LEN_RST;
      cfg_iter_r <= ITER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP:   cfg_step_r <= cfg_data;
        REG_LENGTH: cfg_len_r  <= cfg_data[LEN_W-1:0];
        REG_ITERS:  cfg_iter_r <= cfg_data[IT_W-1:0];
        default: ;
      endcase
    end
  end

  // Derivative table, one write port and one registered read port.
  logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] mem_q;
  logic [AW-1:0]            rd_addr;
  logic                     in_acc;

  logic [4:0]               state_r, ret_r;
  data_t                    y_r;
  logic [WT_W-1:0]          w_r, dt_r;
  logic [KW-1:0]            kl_r;
  logic [DATA_W-1:0]        ay_r;
  logic [KW+WT_W-1:0]       kldt_r;
  logic signed [48:0]       p1_r, pk_r;
  logic signed [33:0]       x_r;
  logic [31:0]              k_r;
  logic [WT_W-1:0]          rem_r;
  logic signed [31:0]       t0_r, t1_r;
  logic signed [34:0]       d_r;
  logic signed [49:0]       q_r;
  logic [IT_W-1:0]          it_r;
  logic                     neg_r;
  data_t                    res_r;
  logic [1:0]               rg_r;
  logic                     out_valid_r;
  data_t                    out_shrunk_r;
  logic [1:0]               out_regime_r;

  // Shared unit registers.
  uword_t                   ua_r, ub_r;
  logic [UW:0]              acc_r;
  logic [6:0]               cnt_r;
  logic                     div_r;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_shrunk = out_shrunk_r;
  assign out_regime = out_regime_r;

  always_ff @(posedge clk) begin
    if (in_acc && in_command == CMD_LOAD && 32'(in_table_index) < 32'(TABLE_DEPTH)) begin
      mem[AW'(in_table_index)] <= in_table_word;
    end
    mem_q <= mem[rd_addr];
  end

  always_comb begin
    case (state_r)
      S_P1:    rd_addr = AW'(kl_r - KW'(1));
      S_KQ:    rd_addr = AW'(ub_r[31:0] - 32'd1);
      S_T0:    rd_addr = AW'(k_r);
      default: rd_addr = '0;
    endcase
  end

  // One adder serves both the multiply (add) and the divide (trial subtract).
  logic [UW:0]   opl;
  logic [UW+1:0] usum;
  assign opl  = div_r ? {acc_r[UW-1:0], ub_r[UW-1]} : acc_r;
  assign usum = {1'b0, opl} + (div_r ? ~{2'b00, ua_r} : {2'b00, ua_r}) + {{(UW+1){1'b0}}, div_r};

  logic signed [49:0] b1, bk, ays, tail_v;
  logic               sgn_pos;
  logic signed [32:0] diff;
  logic signed [34:0] term;
  logic signed [UW-1:0] uq_s, den;
  logic [KW-1:0]      kl_nxt;

  assign b1      = $signed({19'b0, dt_r}) + 50'(p1_r);
  assign bk      = $signed({{(50-KW-WT_W){1'b0}}, kldt_r}) + 50'(pk_r);
  assign ays     = $signed({18'b0, ay_r});
  assign tail_v  = ays - 50'(pk_r);
  assign sgn_pos = !y_r[DATA_W-1] && (y_r != '0);
  assign diff    = 33'(t1_r) - 33'(t0_r);
  assign term    = $signed({1'b0, ub_r[33:0]});
  assign uq_s    = neg_r ? -$signed(ub_r) : $signed(ub_r);
  assign den     = 72'sd65536 + uq_s;

  always_comb begin
    if (cfg_len_r == '0) begin
      kl_nxt = KW'(1);
    end else if (32'(cfg_len_r) > 32'(TABLE_DEPTH)) begin
      kl_nxt = KW'(TABLE_DEPTH);
    end else begin
      kl_nxt = KW'(cfg_len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      cnt_r       <= '0;
      div_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      // Unit step, one bit per cycle.
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 7'd1;
        if (div_r) begin
          if (!usum[UW+1]) begin
            acc_r <= usum[UW:0];
            ub_r  <= {ub_r[UW-2:0], 1'b1};
          end else begin
            acc_r <= opl;
            ub_r  <= {ub_r[UW-2:0], 1'b0};
          end
        end else begin
          if (ub_r[0]) begin
            acc_r <= usum[UW:0];
          end
          ua_r <= ua_r << 1;
          ub_r <= ub_r >> 1;
        end
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_command == CMD_SHRINK) begin
            y_r     <= in_sample;
            w_r     <= in_weight;
            dt_r    <= (cfg_step_r == '0) ? WT_W'(1) : cfg_step_r;
            kl_r    <= kl_nxt;
            ay_r    <= in_sample[DATA_W-1] ? (~in_sample + 32'd1) : in_sample;
            it_r    <= '0;
            state_r <= S_PRE;
          end
        end
        S_PRE: begin
          kldt_r  <= (KW+WT_W)'(kl_r) * (KW+WT_W)'(dt_r);
          state_r <= S_M1;
        end
        S_M1, S_M2: begin
          div_r   <= 1'b0;
          acc_r   <= '0;
          ua_r    <= abs72(72'(mem_q));
          ub_r    <= {41'b0, w_r};
          neg_r   <= mem_q[DATA_W-1];
          cnt_r   <= 7'(MUL_STEPS);
          ret_r   <= (state_r == S_M1) ? S_P1 : S_PK;
          state_r <= S_WAIT;
        end
        S_P1: begin
          p1_r    <= 49'(fl16(acc_r, neg_r));
          state_r <= S_M2;
        end
        S_PK: begin
          pk_r    <= 49'(fl16(acc_r, neg_r));
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (ays < b1) begin
            state_r <= S_Q0M;
          end else if (ays >= bk) begin
            res_r   <= sat32(72'(sgn_pos ? tail_v : -tail_v));
            rg_r    <= RG_TAIL;
            state_r <= S_DONE;
          end else begin
            x_r     <= $signed({2'b0, ay_r});
            state_r <= S_CHK;
          end
        end
        S_Q0M: begin
          div_r   <= 1'b0;
          acc_r   <= '0;
          ua_r    <= {40'b0, ay_r};
          ub_r    <= {41'b0, dt_r};
          cnt_r   <= 7'(MUL_STEPS);
          ret_r   <= S_Q0D;
          state_r <= S_WAIT;
        end
        S_Q0D: begin
          div_r   <= 1'b1;
          acc_r   <= '0;
          ua_r    <= {22'b0, b1};
          ub_r    <= {acc_r[63:0], 8'b0};
          cnt_r   <= 7'd64;
          neg_r   <= y_r[DATA_W-1];
          ret_r   <= S_Q0R;
          state_r <= S_WAIT;
        end
        S_Q0R: begin
          res_r   <= sat32(uq_s);
          rg_r    <= RG_QUAD;
          state_r <= S_DONE;
        end
        S_CHK: begin
          if (it_r == cfg_iter_r) begin
            res_r   <= sat32(72'(sgn_pos ? x_r : -x_r));
            rg_r    <= RG_ITER;
            state_r <= S_DONE;
          end else if (x_r < $signed({3'b0, dt_r})) begin
            res_r   <= y_r;
            rg_r    <= RG_RANGE;
            state_r <= S_DONE;
          end else begin
            div_r   <= 1'b1;
            acc_r   <= '0;
            ua_r    <= {41'b0, dt_r};
            ub_r    <= {x_r[31:0], 40'b0};
            cnt_r   <= 7'd32;
            ret_r   <= S_KQ;
            state_r <= S_WAIT;
          end
        end
        S_KQ: begin
          if (ub_r[31:0] >= 32'(kl_r)) begin
            res_r   <= y_r;
            rg_r    <= RG_RANGE;
            state_r <= S_DONE;
          end else begin
            k_r     <= ub_r[31:0];
            rem_r   <= acc_r[WT_W-1:0];
            state_r <= S_T0;
          end
        end
        S_T0: begin
          t0_r    <= mem_q;
          state_r <= S_T1;
        end
        S_T1: begin
          t1_r    <= mem_q;
          state_r <= S_IM;
        end
        S_IM: begin
          div_r   <= 1'b0;
          acc_r   <= '0;
          ua_r    <= abs72(72'(diff));
          ub_r    <= {41'b0, rem_r};
          neg_r   <= diff[32];
          cnt_r   <= 7'(MUL_STEPS);
          ret_r   <= S_ID;
          state_r <= S_WAIT;
        end
        S_ID: begin
          div_r   <= 1'b1;
          acc_r   <= '0;
          ua_r    <= {41'b0, dt_r};
          ub_r    <= {acc_r[63:0], 8'b0};
          cnt_r   <= 7'd64;
          ret_r   <= S_DD;
          state_r <= S_WAIT;
        end
        S_DD: begin
          d_r     <= 35'(t0_r) + (neg_r ? -term : term);
          state_r <= S_WM;
        end
        S_WM: begin
          div_r   <= 1'b0;
          acc_r   <= '0;
          ua_r    <= abs72(72'(d_r));
          ub_r    <= {41'b0, w_r};
          neg_r   <= d_r[34];
          cnt_r   <= 7'(MUL_STEPS);
          ret_r   <= S_QR;
          state_r <= S_WAIT;
        end
        S_QR: begin
          q_r     <= 50'(fl16(acc_r, neg_r));
          state_r <= S_RD;
        end
        S_RD: begin
          div_r   <= 1'b1;
          acc_r   <= '0;
          ua_r    <= {38'b0, x_r};
          ub_r    <= abs72(72'(q_r)) << 22;
          neg_r   <= q_r[49];
          cnt_r   <= 7'd66;
          ret_r   <= S_DEN;
          state_r <= S_WAIT;
        end
        S_DEN: begin
          if (den == '0) begin
            // Denominator vanished: the iterate pins to the top of the range, or to zero for a zero sample.
            x_r     <= (ay_r == '0) ? 34'sd0 : 34'sd2147483647;
            it_r    <= it_r + 7'd1;
            state_r <= S_CHK;
          end else begin
            div_r   <= 1'b1;
            acc_r   <= '0;
            ua_r    <= abs72(den);
            ub_r    <= {ay_r, 40'b0};
            neg_r   <= den[UW-1];
            cnt_r   <= 7'd48;
            ret_r   <= S_XN;
            state_r <= S_WAIT;
          end
        end
        S_XN: begin
          x_r     <= 34'(sat32(uq_s));
          it_r    <= it_r + 7'd1;
          state_r <= S_CHK;
        end
        S_WAIT: begin
          if (cnt_r == '0) begin
            state_r <= ret_r;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_shrunk_r <= res_r;
            out_regime_r <= rg_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_unit_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (state_r == S_WAIT))
    else $error("shared unit running outside its wait state");

  a_shrink_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command == CMD_SHRINK) |=> !in_ready)
    else $error("accepted a beat while a shrink is in flight");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (it_r <= cfg_iter_r))
    else $error("iteration count ran past its limit");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && $past(rst_n)) |=> (!out_valid || $past(state_r == S_DONE)))
    else $error("result raised outside the finishing state");

endmodule

[sim/tb_tabulated_shrinkage_solver.sv]
`timescale 1ns / 1ps

module tb_tabulated_shrinkage_solver;
  import tss_pkg::*;

  localparam int  DEPTH     = 1024;
  localparam longint ONE_Q  = 65536;
  localparam longint MAX32  = 64'sd2147483647;
  localparam longint MIN32  = -64'sd2147483648;
  localparam longint CYCLE_LIMIT = 8000000;

  typedef struct packed {
    logic signed [DATA_W-1:0] shrunk;
    logic [1:0]               regime;
  } shrink_res_t;

  typedef struct packed {
    logic                     cmd;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] word;
    logic signed [DATA_W-1:0] smp;
    logic [WT_W-1:0]          wt;
    logic                     known;
    logic signed [DATA_W-1:0] e_shrunk;
    logic [1:0]               e_regime;
  } plan_row_t;

  typedef struct {
    logic [WT_W-1:0]  step;
    logic [WT_W-1:0]  len;
    logic [WT_W-1:0]  iters;
    int               count;
  } phase_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_command;
  logic [IDX_W-1:0] in_table_index;
  logic signed [DATA_W-1:0] in_table_word, in_sample;
  logic [WT_W-1:0] in_weight;
  logic out_valid, out_ready;
  logic signed [DATA_W-1:0] out_shrunk;
  logic [1:0] out_regime;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WT_W-1:0] cfg_data;

  tabulated_shrinkage_solver uut (.*);

  // Mirror of the block's table and registers.
  longint          deriv_tbl [DEPTH];
  logic [WT_W-1:0] spacing_reg;
  logic [LEN_W-1:0] length_reg;
  logic [IT_W-1:0] iters_reg;

  shrink_res_t pending_results[$];
  int   err_count = 0;
  bit   calm = 0;
  longint cycles = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic longint floor_q16(input longint v);
    if (v >= 0) return v >>> 16;
    return -((-v + 65535) >>> 16);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > MAX32) return MAX32;
    if (v < MIN32) return MIN32;
    return v;
  endfunction

  function automatic shrink_res_t shrink_predict(input logic signed [DATA_W-1:0] ys,
                                                 input logic [WT_W-1:0] ws);
    longint y, ay, w, dt, kl, p1, b1, pk, bk, x, res, k, t0, t1, diff, term, d, q, r, den;
    longint unsigned mag;
    logic [1:0] rg;
    shrink_res_t o;
    y  = ys;
    w  = ws;
    dt = (spacing_reg == 0) ? 1 : spacing_reg;
    kl = length_reg;
    if (kl < 1) kl = 1;
    if (kl > DEPTH) kl = DEPTH;
    ay = (y < 0) ? -y : y;
    p1 = floor_q16(w * deriv_tbl[0]);
    b1 = dt + p1;
    pk = floor_q16(w * deriv_tbl[kl-1]);
    bk = kl * dt + pk;
    if (ay < b1) begin
      res = (y * dt) / b1;
      rg  = RG_QUAD;
    end else if (ay >= bk) begin
      res = (y > 0) ? (ay - pk) : -(ay - pk);
      rg  = RG_TAIL;
    end else begin
      x  = ay;
      rg = RG_ITER;
      for (int it = 0; it < iters_reg; it++) begin
        if (x < dt || x / dt >= kl) begin
          rg = RG_RANGE;
          break;
        end
        k    = x / dt;
        t0   = deriv_tbl[k-1];
        t1   = deriv_tbl[k];
        diff = t1 - t0;
        mag  = longint'(x - k * dt) * longint'((diff < 0) ? -diff : diff);
        mag  = mag / longint'(dt);
        term = (diff < 0) ? -longint'(mag) : longint'(mag);
        d    = t0 + term;
        q    = floor_q16(w * d);
        r    = (q * ONE_Q) / x;
        den  = ONE_Q + r;
        if (den == 0) x = (ay != 0) ? MAX32 : 0;
        else x = clamp32((ay * ONE_Q) / den);
      end
      if (rg == RG_RANGE) res = y;
      else res = (y > 0) ? x : -x;
    end
    o.shrunk = DATA_W'(clamp32(res));
    o.regime = rg;
    return o;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    shrink_res_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %h/%0d", out_shrunk, out_regime));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_shrunk !== exp_r.shrunk)
          report($sformatf("shrunk %h, expected %h", out_shrunk, exp_r.shrunk));
        if (out_regime !== exp_r.regime)
          report($sformatf("regime %0d, expected %0d", out_regime, exp_r.regime));
      end
    end
  end

  // Receiver with random stall bursts.
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (!calm && rst_n && $urandom_range(0, 7) == 0) begin
        out_ready = 0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready = 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input plan_row_t b);
    shrink_res_t e;
    in_valid       = 1;
    in_command     = b.cmd;
    in_table_index = b.idx;
    in_table_word  = b.word;
    in_sample      = b.smp;
    in_weight      = b.wt;
    do @(posedge clk); while (!in_ready);
    if (b.cmd == CMD_LOAD) begin
      deriv_tbl[b.idx] = longint'(b.word);
    end else begin
      e = shrink_predict(b.smp, b.wt);
      if (b.known) begin
        e.shrunk = b.e_shrunk;
        e.regime = b.e_regime;
      end
      pending_results.push_back(e);
    end
    @(negedge clk);
  endtask

  task automatic pause_in(input int n);
    in_valid = 0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WT_W-1:0] val);
    cfg_we    = 1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      REG_STEP:   spacing_reg = val;
      REG_LENGTH: length_reg  = val[LEN_W-1:0];
      REG_ITERS:  iters_reg   = val[IT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [DATA_W-1:0] mild_word();
    if ($urandom_range(0, 15) == 0) return $urandom;
    return $signed($urandom_range(0, 6 * 65536)) - 2 * 65536;
  endfunction

  function automatic plan_row_t random_beat();
    plan_row_t b;
    longint dt, kl, span, ay;
    int sel;
    b = '0;
    b.cmd = CMD_SHRINK;
    b.idx = IDX_W'($urandom);
    b.word = $urandom;
    b.wt = WT_W'((($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4 * 65536)));
    dt = (spacing_reg == 0) ? 1 : spacing_reg;
    kl = length_reg;
    if (kl < 1) kl = 1;
    if (kl > DEPTH) kl = DEPTH;
    span = kl * dt + dt;
    if (span > MAX32) span = MAX32;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      // Mostly aim between the knees so the iteration runs.
      ay = longint'({$urandom, $urandom} % longint'(span + 1));
      b.smp = DATA_W'($urandom_range(0, 1) ? -ay : ay);
    end else if (sel < 8) begin
      b.smp = $urandom;
    end else if (sel < 9) begin
      b.smp = $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
    end else begin
      b.cmd  = CMD_LOAD;
      b.word = mild_word();
    end
    return b;
  endfunction

  plan_row_t plan [];
  phase_t    phases [];

  initial begin
    plan_row_t b;
    rst_n = 0;
    in_valid = 0;
    in_command = 0;
    in_table_index = 0;
    in_table_word = 0;
    in_sample = 0;
    in_weight = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    spacing_reg = STEP_RST;
    length_reg  = LEN_RST;
    iters_reg   = ITER_RST;
    repeat (10) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Fill the whole table first so that every later read hits a written entry.
    for (int i = 0; i < DEPTH; i++) begin
      b = '0;
      b.cmd  = CMD_LOAD;
      b.idx  = IDX_W'(i);
      b.word = (i == 0) ? 0 : $urandom_range(0, 2 * 65536);
      send_beat(b);
    end

    plan = '{
      '{CMD_SHRINK, 10'd0,    32'sd0,       32'sd0,       31'd0,
        1'b1, 32'sd0, RG_QUAD},
      '{CMD_SHRINK, 10'd0,    32'sd0,       32'h7fffffff, 31'd0,
        1'b1, 32'h7fffffff, RG_TAIL},
      '{CMD_SHRINK, 10'd0,    32'sd0,       32'h80000000, 31'd0,
        1'b1, 32'h80000000, RG_TAIL},
      '{CMD_SHRINK, 10'd0,    32'sd0,       32'h00018000, 31'h10000,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_SHRINK, 10'd0,    32'sd0,       -32'sh50000,  31'h8000,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_SHRINK, 10'd0,    32'sd0,       32'h00200000, 31'h7fffffff,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_LOAD,   10'd1023, 32'h7fffffff, 32'sd0,       31'd0,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_SHRINK, 10'd0,    32'sd0,       32'h03ff0000, 31'h10000,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_SHRINK, 10'd0,    32'sd0,       32'h7fffffff, 31'h7fffffff,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_LOAD,   10'd1023, 32'h80000000, 32'sd0,       31'd0,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_SHRINK, 10'd0,    32'sd0,       32'h7fffffff, 31'h10000,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_SHRINK, 10'd0,    32'sd0,       32'h80000000, 31'h7fffffff,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_LOAD,   10'd1023, 32'h00010000, 32'sd0,       31'd0,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_LOAD,   10'd0,    -32'sh20000,  32'sd0,       31'd0,
        1'b0, 32'sd0, RG_QUAD},
      // A zero sample with a negative first knee lands between the knees.
      '{CMD_SHRINK, 10'd0,    32'sd0,       32'sd0,       31'h10000,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_SHRINK, 10'd0,    32'sd0,       32'h00030000, 31'h10000,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_LOAD,   10'd0,    32'h80000000, 32'sd0,       31'd0,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_SHRINK, 10'd0,    32'sd0,       32'h00030000, 31'h10000,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_LOAD,   10'd0,    32'sd0,       32'sd0,       31'd0,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_SHRINK, 10'd0,    32'sd0,       -32'sh00123456, 31'h00018000,
        1'b0, 32'sd0, RG_QUAD},
      '{CMD_SHRINK, 10'd0,    32'sd0,       32'h02000000, 31'h00020000,
        1'b0, 32'sd0, RG_QUAD}
    };
    foreach (plan[i]) send_beat(plan[i]);

    phases = '{
      '{31'd65536,      31'd1024, 31'd3,  110},
      '{31'd0,          31'd2,    31'd1,  40},
      '{31'h7fffffff,   31'd2,    31'd2,  30},
      '{31'd16384,      31'd0,    31'd4,  40},
      '{31'd32768,      31'd2047, 31'd5,  60},
      '{31'd100000,     31'd300,  31'd0,  40},
      '{31'd65536,      31'd64,   31'd64, 15},
      '{31'd20000,      31'd1000, 31'd6,  100},
      '{31'd65536,      31'd1024, 31'd2,  105}
    };
    foreach (phases[p]) begin
      drain_results();
      repeat (100) @(negedge clk);
      write_reg(REG_STEP,   phases[p].step);
      write_reg(REG_LENGTH, phases[p].len);
      write_reg(REG_ITERS,  phases[p].iters);
      if (p == phases.size() - 1) calm = 1;
      for (int n = 0; n < phases[p].count; n++) begin
        if (!calm && $urandom_range(0, 3) == 0) pause_in($urandom_range(1, 19));
        if (p == 0 && n == 20) drain_results();
        send_beat(random_beat());
      end
    end

    drain_results();
    repeat (200) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
